// File: src/isoep_pkg.sv
// ----------------------------------------------------------------------------
// isoep_pkg
// Shared types, constants and small tables for the ISO 8601 to epoch parser.
// ----------------------------------------------------------------------------
package isoep_pkg;

  localparam int MAX_DIGITS = 9;
  localparam int ACC_W      = $clog2(10 ** MAX_DIGITS);
  localparam int DC_W       = $clog2(MAX_DIGITS + 1);
  localparam int FIELD_W    = 32;
  localparam int NUM_FIELDS = 8;
  localparam int FI_W       = 4;
  localparam int OFFSET_W   = 17;
  localparam int EPOCH_W    = 64;
  localparam int MUL_A_W    = 33;
  localparam int MUL_B_W    = 30;
  localparam int DAY_SHIFT  = 7;     // 86400 = 675 << 7

  // field indexes
  localparam logic [FI_W-1:0] FI_MONTH = 4'd1;
  localparam logic [FI_W-1:0] FI_SEC   = 4'd5;
  localparam logic [FI_W-1:0] FI_ZHOUR = 4'd6;
  localparam logic [FI_W-1:0] FI_ZMIN  = 4'd7;
  localparam logic [FI_W-1:0] FI_DONE  = 4'd8;

  // ASCII codes
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;

  // floor(y/400) = floor(floor(y/16)/25); the /25 is a reciprocal multiply
  // on a biased, positive value below 2^29
  localparam logic [MUL_B_W-1:0] DIV25_MUL   = 30'd687194768;
  localparam int                 DIV25_SHIFT = 34;
  localparam logic [28:0]        W_BIAS      = 29'd209715200;  // 25 << 23
  localparam logic [23:0]        ERA_BIAS    = 24'd8388608;    // 1 << 23

  localparam logic [MUL_B_W-1:0] K_400       = 30'd400;
  localparam logic [MUL_B_W-1:0] K_365       = 30'd365;
  localparam logic [MUL_B_W-1:0] K_675       = 30'd675;
  localparam logic [MUL_B_W-1:0] K_ERA_DAY   = 30'd98615475;   // 146097 * 675
  localparam logic [MUL_B_W-1:0] K_3600      = 30'd3600;
  localparam logic [MUL_B_W-1:0] K_60        = 30'd60;
  localparam logic [MUL_B_W-1:0] K_1         = 30'd1;
  localparam logic [20:0]        DAY_BIAS    = 21'd719469;     // 719468 + 1

  typedef enum logic [1:0] {
    ZONE_NONE,
    ZONE_Z,
    ZONE_PLUS,
    ZONE_MINUS
  } zone_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FIN,
    ST_CHECK,
    ST_DIVQ,
    ST_ERA,
    ST_YOEM,
    ST_YOE,
    ST_DOEM,
    ST_DOE,
    ST_DAY,
    ST_SMALL,
    ST_HOUR,
    ST_MIN,
    ST_SEC,
    ST_OFF1,
    ST_OFF2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic finish;
    logic clear;
  } parse_ctl_t;

  typedef struct packed {
    logic [FI_W-1:0] field_index;
    logic            failed;
    zone_t           zone;
  } parse_stat_t;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0]        b;
    acc_op_t                   op;
    logic                      sh_day;
  } mac_ctl_t;

  function automatic logic [7:0] sep_char(input logic [FI_W-1:0] fi);
    logic [7:0] c;
    priority if (fi == 4'd2) c = CH_T;
    else if (fi >= 4'd3)     c = CH_COLON;
    else                     c = CH_MINUS;
    return c;
  endfunction

  // days before month, March-based year: (153*mp + 2) / 5
  function automatic logic [8:0] days_before(input logic [3:0] mp);
    logic [8:0] d;
    unique case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // yoe / 100 for yoe in 0..399
  function automatic logic [1:0] centuries(input logic [8:0] yoe);
    logic [1:0] c;
    priority if (yoe >= 9'd300) c = 2'd3;
    else if (yoe >= 9'd200)     c = 2'd2;
    else if (yoe >= 9'd100)     c = 2'd1;
    else                        c = 2'd0;
    return c;
  endfunction

endpackage

// File: src/isoep_parser.sv
// ----------------------------------------------------------------------------
// isoep_parser
// Byte-level scanner: collects the date, time and zone numbers of the text.
// ----------------------------------------------------------------------------
module isoep_parser (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  isoep_pkg::parse_ctl_t                            ctl,
  input  logic [7:0]                                       text_byte,
  output isoep_pkg::parse_stat_t                           stat,
  output logic [isoep_pkg::NUM_FIELDS-1:0][isoep_pkg::FIELD_W-1:0] fields
);

  logic [isoep_pkg::FI_W-1:0]    fi_r, fi_nxt;
  logic [isoep_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic                          neg_r, neg_nxt;
  logic [isoep_pkg::DC_W-1:0]    dc_r, dc_nxt;
  logic                          sign_r, sign_nxt;
  isoep_pkg::zone_t              zone_r, zone_nxt;
  logic                          failed_r, failed_nxt;
  logic [isoep_pkg::FIELD_W-1:0] fields_r [isoep_pkg::NUM_FIELDS];

  logic                          store_en;
  logic [isoep_pkg::FIELD_W-1:0] mag, store_val;
  logic                          is_digit, is_space, is_plus, is_minus;

  assign is_digit = (text_byte >= isoep_pkg::CH_0) && (text_byte <= isoep_pkg::CH_9);
  assign is_space = (text_byte == isoep_pkg::CH_SPACE) ||
                    ((text_byte >= isoep_pkg::CH_TAB) && (text_byte <= isoep_pkg::CH_CR));
  assign is_plus  = (text_byte == isoep_pkg::CH_PLUS);
  assign is_minus = (text_byte == isoep_pkg::CH_MINUS);

  assign mag       = {{(isoep_pkg::FIELD_W-isoep_pkg::ACC_W){1'b0}}, acc_r};
  assign store_val = neg_r ? (~mag + 1'b1) : mag;

  always_comb begin
    fi_nxt     = fi_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    dc_nxt     = dc_r;
    sign_nxt   = sign_r;
    zone_nxt   = zone_r;
    failed_nxt = failed_r;
    store_en   = 1'b0;
    if (ctl.clear) begin
      fi_nxt     = '0;
      acc_nxt    = '0;
      neg_nxt    = 1'b0;
      dc_nxt     = '0;
      sign_nxt   = 1'b0;
      zone_nxt   = isoep_pkg::ZONE_NONE;
      failed_nxt = 1'b0;
    end else if (ctl.finish) begin
      // close a number that runs up to the end of the text
      if (!failed_r && (fi_r < isoep_pkg::FI_DONE) && (dc_r != '0)) begin
        store_en = 1'b1;
        acc_nxt  = '0;
        neg_nxt  = 1'b0;
        dc_nxt   = '0;
        sign_nxt = 1'b0;
        if ((fi_r == isoep_pkg::FI_SEC) || (fi_r == isoep_pkg::FI_ZMIN)) begin
          fi_nxt = isoep_pkg::FI_DONE;
        end
      end
    end else if (ctl.take && !failed_r && (fi_r < isoep_pkg::FI_DONE)) begin
      if (is_digit) begin
        if (dc_r >= isoep_pkg::DC_W'(isoep_pkg::MAX_DIGITS)) begin
          failed_nxt = 1'b1;
        end else begin
          acc_nxt = acc_r * isoep_pkg::ACC_W'(10) + isoep_pkg::ACC_W'(text_byte[3:0]);
          dc_nxt  = dc_r + 1'b1;
        end
      end else if (dc_r == '0) begin
        priority if (!sign_r && is_space) begin
          failed_nxt = failed_r;
        end else if (!sign_r && (is_plus || is_minus)) begin
          sign_nxt = 1'b1;
          neg_nxt  = is_minus;
        end else begin
          failed_nxt = 1'b1;
        end
      end else begin
        // terminator of the current number
        store_en = 1'b1;
        acc_nxt  = '0;
        neg_nxt  = 1'b0;
        dc_nxt   = '0;
        sign_nxt = 1'b0;
        priority if (fi_r < isoep_pkg::FI_SEC) begin
          if (text_byte == isoep_pkg::sep_char(fi_r)) fi_nxt = fi_r + 1'b1;
          else                                         failed_nxt = 1'b1;
        end else if (fi_r == isoep_pkg::FI_SEC) begin
          priority if (text_byte == isoep_pkg::CH_Z) begin
            zone_nxt = isoep_pkg::ZONE_Z;
            fi_nxt   = isoep_pkg::FI_DONE;
          end else if (is_plus) begin
            zone_nxt = isoep_pkg::ZONE_PLUS;
            fi_nxt   = isoep_pkg::FI_ZHOUR;
          end else if (is_minus) begin
            zone_nxt = isoep_pkg::ZONE_MINUS;
            fi_nxt   = isoep_pkg::FI_ZHOUR;
          end else begin
            failed_nxt = 1'b1;
          end
        end else if (fi_r == isoep_pkg::FI_ZHOUR) begin
          if (text_byte == isoep_pkg::CH_COLON) fi_nxt = isoep_pkg::FI_ZMIN;
          else                                  failed_nxt = 1'b1;
        end else begin
          fi_nxt = isoep_pkg::FI_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fi_r     <= '0;
      acc_r    <= '0;
      neg_r    <= 1'b0;
      dc_r     <= '0;
      sign_r   <= 1'b0;
      zone_r   <= isoep_pkg::ZONE_NONE;
      failed_r <= 1'b0;
    end else begin
      fi_r     <= fi_nxt;
      acc_r    <= acc_nxt;
      neg_r    <= neg_nxt;
      dc_r     <= dc_nxt;
      sign_r   <= sign_nxt;
      zone_r   <= zone_nxt;
      failed_r <= failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      fields_r[fi_r[2:0]] <= store_val;
    end
  end

  always_comb begin
    for (int i = 0; i < isoep_pkg::NUM_FIELDS; i++) begin
      fields[i] = fields_r[i];
    end
  end

  assign stat.field_index = fi_r;
  assign stat.failed      = failed_r;
  assign stat.zone        = zone_r;

endmodule

// File: src/isoep_mac.sv
// ----------------------------------------------------------------------------
// isoep_mac
// Shared multiply-accumulate unit: registered product, then a 64-bit
// add or subtract into the accumulator on the following cycle.
// ----------------------------------------------------------------------------
module isoep_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  isoep_pkg::mac_ctl_t                 ctl,
  output logic signed [isoep_pkg::EPOCH_W-1:0] prod,
  output logic signed [isoep_pkg::EPOCH_W-1:0] acc
);

  logic signed [isoep_pkg::EPOCH_W-1:0] prod_r, acc_r, acc_nxt;
  logic signed [isoep_pkg::EPOCH_W-1:0] a_ext, b_ext, term;

  assign a_ext = isoep_pkg::EPOCH_W'(ctl.a);
  assign b_ext = $signed({{(isoep_pkg::EPOCH_W-isoep_pkg::MUL_B_W){1'b0}}, ctl.b});
  assign term  = ctl.sh_day ? (prod_r <<< isoep_pkg::DAY_SHIFT) : prod_r;

  always_comb begin
    unique case (ctl.op)
      isoep_pkg::ACC_HOLD:  acc_nxt = acc_r;
      isoep_pkg::ACC_CLEAR: acc_nxt = '0;
      isoep_pkg::ACC_ADD:   acc_nxt = acc_r + term;
      isoep_pkg::ACC_SUB:   acc_nxt = acc_r - term;
      default:              acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= a_ext * b_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

// File: src/iso8601_to_epoch_parser_core.sv
// ----------------------------------------------------------------------------
// iso8601_to_epoch_parser_core
// ISO 8601 date-time text to signed Unix seconds.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes of the text YYYY-MM-DDTHH:MM:SS[Z|+HH:MM|-HH:MM] enter on the in_
//   channel (valid/ready), one per cycle, in_last_byte marking the final one.
//   Non-final bytes give no result. The final byte starts the conversion and
//   one transaction leaves on the out_ channel: epoch seconds, status (1 on
//   malformed text, epoch then 0) and whether a zone was present.
//   Conversion runs on one shared multiply-accumulate unit under a sequencer:
//   a valid text steps through every multiply state, while a malformed one
//   goes from the check straight to loading its result. in_ready is low from the
//   final byte until the result is loaded into the output register, then the
//   next text may start. If out_ready is low the result waits in the output
//   register; a following text may be scanned and converted meanwhile, but
//   its result holds until the register is free.
//   cfg_wr_en writes cfg_wr_data as the local offset in seconds, used when
//   the text carries no zone; write it only while the block is idle.
//   Reset (rst_n low, synchronous) clears the scanner, the output valid flag
//   and the local offset to zero.
// ----------------------------------------------------------------------------
module iso8601_to_epoch_parser_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            in_text_byte,
  input  logic                                  in_last_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [isoep_pkg::EPOCH_W-1:0]  out_epoch_seconds,
  output logic                                  out_status,
  output logic                                  out_zone_given,
  input  logic                                  cfg_wr_en,
  input  logic signed [isoep_pkg::OFFSET_W-1:0] cfg_wr_data
);

  isoep_pkg::state_t      state_r, state_nxt;
  isoep_pkg::parse_ctl_t  pctl;
  isoep_pkg::parse_stat_t pstat;
  isoep_pkg::mac_ctl_t    mctl;

  logic [isoep_pkg::NUM_FIELDS-1:0][isoep_pkg::FIELD_W-1:0] fields;
  logic signed [isoep_pkg::EPOCH_W-1:0] prod, acc;

  logic signed [isoep_pkg::OFFSET_W-1:0] local_off_r;
  logic signed [32:0]                    y_r, y_nxt;
  logic [28:0]                           w_r;
  logic [3:0]                            mp_r, mp_nxt;
  logic [23:0]                           era_r;
  logic [8:0]                            yoe_r;
  logic [20:0]                           small_r;
  logic                                  err_r;

  logic                                  out_valid_r;
  logic signed [isoep_pkg::EPOCH_W-1:0]  out_epoch_r;
  logic                                  out_status_r, out_zone_r;

  logic signed [isoep_pkg::FIELD_W-1:0]  month;
  logic                                  early_month, ok, out_free, accept;
  logic                                  numeric_zone;
  isoep_pkg::acc_op_t                    zone_op;

  isoep_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (pctl),
    .text_byte (in_text_byte),
    .stat      (pstat),
    .fields    (fields)
  );

  isoep_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mctl),
    .prod  (prod),
    .acc   (acc)
  );

  assign month        = $signed(fields[isoep_pkg::FI_MONTH[2:0]]);
  assign early_month  = (month <= 32'sd2);
  assign ok           = !pstat.failed && (pstat.field_index == isoep_pkg::FI_DONE) &&
                        (month >= 32'sd1) && (month <= 32'sd12);
  assign out_free     = !out_valid_r || out_ready;
  assign accept       = in_valid && in_ready;
  assign numeric_zone = (pstat.zone == isoep_pkg::ZONE_PLUS) ||
                        (pstat.zone == isoep_pkg::ZONE_MINUS);
  assign zone_op      = (pstat.zone == isoep_pkg::ZONE_MINUS) ? isoep_pkg::ACC_ADD
                                                              : isoep_pkg::ACC_SUB;

  // year shifted so that March starts it
  assign y_nxt  = $signed({fields[0][31], fields[0]}) - (early_month ? 33'sd1 : 33'sd0);
  assign mp_nxt = early_month ? (month[3:0] + 4'd9) : (month[3:0] - 4'd3);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      isoep_pkg::ST_IDLE:  if (accept && in_last_byte) state_nxt = isoep_pkg::ST_FIN;
      isoep_pkg::ST_FIN:   state_nxt = isoep_pkg::ST_CHECK;
      isoep_pkg::ST_CHECK: state_nxt = ok ? isoep_pkg::ST_DIVQ : isoep_pkg::ST_DONE;
      isoep_pkg::ST_DIVQ:  state_nxt = isoep_pkg::ST_ERA;
      isoep_pkg::ST_ERA:   state_nxt = isoep_pkg::ST_YOEM;
      isoep_pkg::ST_YOEM:  state_nxt = isoep_pkg::ST_YOE;
      isoep_pkg::ST_YOE:   state_nxt = isoep_pkg::ST_DOEM;
      isoep_pkg::ST_DOEM:  state_nxt = isoep_pkg::ST_DOE;
      isoep_pkg::ST_DOE:   state_nxt = isoep_pkg::ST_DAY;
      isoep_pkg::ST_DAY:   state_nxt = isoep_pkg::ST_SMALL;
      isoep_pkg::ST_SMALL: state_nxt = isoep_pkg::ST_HOUR;
      isoep_pkg::ST_HOUR:  state_nxt = isoep_pkg::ST_MIN;
      isoep_pkg::ST_MIN:   state_nxt = isoep_pkg::ST_SEC;
      isoep_pkg::ST_SEC:   state_nxt = isoep_pkg::ST_OFF1;
      isoep_pkg::ST_OFF1:  state_nxt = isoep_pkg::ST_OFF2;
      isoep_pkg::ST_OFF2:  state_nxt = isoep_pkg::ST_DONE;
      isoep_pkg::ST_DONE:  if (out_free) state_nxt = isoep_pkg::ST_IDLE;
      default:             state_nxt = isoep_pkg::ST_IDLE;
    endcase
  end

  // outputs: scanner control and MAC schedule (product issued one state,
  // accumulated the next)
  always_comb begin
    in_ready     = (state_r == isoep_pkg::ST_IDLE);
    pctl.take    = in_valid && (state_r == isoep_pkg::ST_IDLE);
    pctl.finish  = (state_r == isoep_pkg::ST_FIN);
    pctl.clear   = (state_r == isoep_pkg::ST_DONE) && out_free;
    mctl.a       = '0;
    mctl.b       = '0;
    mctl.op      = isoep_pkg::ACC_HOLD;
    mctl.sh_day  = 1'b0;
    unique case (state_r)
      isoep_pkg::ST_DIVQ: begin
        mctl.a = $signed({4'b0, w_r});
        mctl.b = isoep_pkg::DIV25_MUL;
      end
      isoep_pkg::ST_YOEM: begin
        mctl.a = $signed({{9{era_r[23]}}, era_r});
        mctl.b = isoep_pkg::K_400;
      end
      isoep_pkg::ST_YOE: begin
        mctl.a  = $signed({{9{era_r[23]}}, era_r});
        mctl.b  = isoep_pkg::K_ERA_DAY;
        mctl.op = isoep_pkg::ACC_CLEAR;
      end
      isoep_pkg::ST_DOEM: begin
        mctl.a      = $signed({24'b0, yoe_r});
        mctl.b      = isoep_pkg::K_365;
        mctl.op     = isoep_pkg::ACC_ADD;
        mctl.sh_day = 1'b1;
      end
      isoep_pkg::ST_DOE: begin
        mctl.a = $signed({fields[2][31], fields[2]});
        mctl.b = isoep_pkg::K_675;
      end
      isoep_pkg::ST_DAY: begin
        mctl.a      = $signed({{12{small_r[20]}}, small_r});
        mctl.b      = isoep_pkg::K_675;
        mctl.op     = isoep_pkg::ACC_ADD;
        mctl.sh_day = 1'b1;
      end
      isoep_pkg::ST_SMALL: begin
        mctl.a      = $signed({fields[3][31], fields[3]});
        mctl.b      = isoep_pkg::K_3600;
        mctl.op     = isoep_pkg::ACC_ADD;
        mctl.sh_day = 1'b1;
      end
      isoep_pkg::ST_HOUR: begin
        mctl.a  = $signed({fields[4][31], fields[4]});
        mctl.b  = isoep_pkg::K_60;
        mctl.op = isoep_pkg::ACC_ADD;
      end
      isoep_pkg::ST_MIN: begin
        mctl.a  = $signed({fields[5][31], fields[5]});
        mctl.b  = isoep_pkg::K_1;
        mctl.op = isoep_pkg::ACC_ADD;
      end
      isoep_pkg::ST_SEC: begin
        mctl.op = isoep_pkg::ACC_ADD;
        priority if (numeric_zone) begin
          mctl.a = $signed({fields[6][31], fields[6]});
          mctl.b = isoep_pkg::K_3600;
        end else if (pstat.zone == isoep_pkg::ZONE_NONE) begin
          mctl.a = $signed({{16{local_off_r[16]}}, local_off_r});
          mctl.b = isoep_pkg::K_1;
        end else begin
          mctl.a = '0;
          mctl.b = isoep_pkg::K_1;
        end
      end
      isoep_pkg::ST_OFF1: begin
        mctl.op = zone_op;
        mctl.a  = numeric_zone ? $signed({fields[7][31], fields[7]}) : '0;
        mctl.b  = isoep_pkg::K_60;
      end
      isoep_pkg::ST_OFF2: begin
        mctl.op = zone_op;
      end
      default: begin
        mctl.op = isoep_pkg::ACC_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= isoep_pkg::ST_IDLE;
      local_off_r <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        local_off_r <= cfg_wr_data;
      end
      if (state_r == isoep_pkg::ST_CHECK) begin
        err_r <= !ok;
      end
      if ((state_r == isoep_pkg::ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // conversion datapath
  always_ff @(posedge clk) begin
    if (state_r == isoep_pkg::ST_CHECK) begin
      y_r  <= y_nxt;
      w_r  <= y_nxt[32:4] + isoep_pkg::W_BIAS;
      mp_r <= mp_nxt;
    end
    if (state_r == isoep_pkg::ST_ERA) begin
      era_r <= prod[isoep_pkg::DIV25_SHIFT+23:isoep_pkg::DIV25_SHIFT] - isoep_pkg::ERA_BIAS;
    end
    if (state_r == isoep_pkg::ST_YOE) begin
      yoe_r <= y_r[8:0] - prod[8:0];
    end
    if (state_r == isoep_pkg::ST_DOE) begin
      // yoe*365 + yoe/4 - yoe/100 + days before month - 1 - 719468
      small_r <= prod[20:0] + {14'b0, yoe_r[8:2]} - {19'b0, isoep_pkg::centuries(yoe_r)}
               + {12'b0, isoep_pkg::days_before(mp_r)} - isoep_pkg::DAY_BIAS;
    end
    if ((state_r == isoep_pkg::ST_DONE) && out_free) begin
      out_epoch_r  <= err_r ? '0 : acc;
      out_status_r <= err_r;
      out_zone_r   <= !err_r && (pstat.zone != isoep_pkg::ZONE_NONE);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_epoch_seconds = out_epoch_r;
  assign out_status        = out_status_r;
  assign out_zone_given    = out_zone_r;

endmodule

// File: sim/iso8601_to_epoch_parser_core_tb.sv
// ----------------------------------------------------------------------------
// iso8601_to_epoch_parser_core_tb
// Self-checking bench for the ISO 8601 text to Unix seconds converter.
// Date-time texts are sent one byte per transaction and scanned by a
// behavioural copy of the converter. Each result transaction is compared
// with the oldest predicted conversion. A short table of hand-picked texts
// comes first, followed by randomised texts across several local offsets,
// with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module iso8601_to_epoch_parser_core_tb;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_BYTES  = 170;
  localparam int N_PHASES     = 5;
  localparam int N_DIRECTED   = 26;

  typedef struct packed {
    logic signed [isoep_pkg::EPOCH_W-1:0] epoch;
    logic                                 status;
    logic                                 zone;
  } epoch_result_t;

  typedef struct {
    string  text;
    int     offset;
    bit     typed;
    longint epoch;
    bit     status;
    bit     zone;
  } text_case_t;

  logic                                  clk = 1'b0;
  logic                                  rst_n;
  logic                                  in_valid;
  logic                                  in_ready;
  logic [7:0]                            in_text_byte;
  logic                                  in_last_byte;
  logic                                  out_valid;
  logic                                  out_ready;
  logic signed [isoep_pkg::EPOCH_W-1:0]  out_epoch_seconds;
  logic                                  out_status;
  logic                                  out_zone_given;
  logic                                  cfg_wr_en;
  logic signed [isoep_pkg::OFFSET_W-1:0] cfg_wr_data;

  iso8601_to_epoch_parser_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_text_byte      (in_text_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_epoch_seconds (out_epoch_seconds),
    .out_status        (out_status),
    .out_zone_given    (out_zone_given),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // scanner copy
  logic [isoep_pkg::FI_W-1:0] scan_field;
  logic [31:0]                scan_acc;
  bit                         scan_neg;
  int                         scan_digits;
  bit                         scan_sign_seen;
  int                         field_vals [isoep_pkg::NUM_FIELDS];
  isoep_pkg::zone_t           scan_zone;
  bit                         scan_bad;
  int                         local_off;

  epoch_result_t   pending_epochs [$];
  logic [7:0]      txt [$];

  bit calm     = 1'b0;
  int hold_req = 0;
  int mismatches = 0;
  int n_bytes = 0, n_texts = 0, n_results = 0, n_rejected = 0, n_offsets = 0;

  text_case_t directed_cases [N_DIRECTED] = '{
    '{"1970-01-01T00:00:00Z",           0, 1, 0, 0, 1},
    '{"1970-01-01T00:00:00",            0, 1, 0, 0, 0},
    '{"9999-12-31T23:59:59Z",           0, 1, 64'sd253402300799, 0, 1},
    '{"0000-01-01T00:00:00Z",           0, 1, -64'sd62167219200, 0, 1},
    '{"-999999999-01-01T00:00:00Z",     0, 0, 0, 0, 0},
    '{"999999999-12-31T999999999:999999999:999999999+999999999:999999999",
                                        0, 0, 0, 0, 0},
    '{"-999999999-12--999999999T-999999999:-999999999:-999999999-999999999:999999999",
                                        0, 0, 0, 0, 0},
    '{"2024-02-29T12:34:56+05:30",      0, 0, 0, 0, 0},
    '{"2024-02-29T12:34:56-23:59",      0, 0, 0, 0, 0},
    '{" 2000-\t01-\n01T\f00:\v00: 00Z", 0, 0, 0, 0, 0},
    '{"+1970-+01-01T00:00:00Z",         0, 1, 0, 0, 1},
    '{"+-1970-01-01T00:00:00Z",         0, 1, 0, 1, 0},
    '{"+ 1970-01-01T00:00:00Z",         0, 1, 0, 1, 0},
    '{"1970-01-01T00::00:00Z",          0, 1, 0, 1, 0},
    '{"1970-01-01T00:00:00X",           0, 1, 0, 1, 0},
    '{"1970/01-01T00:00:00Z",           0, 1, 0, 1, 0},
    '{"1234567890-01-01T00:00:00Z",     0, 1, 0, 1, 0},
    '{"1970-13-01T00:00:00Z",           0, 1, 0, 1, 0},
    '{"1970-00-01T00:00:00Z",           0, 1, 0, 1, 0},
    '{"1970-01-01T00:00",               0, 1, 0, 1, 0},
    '{"1970-01-01T00:00:00+05",         0, 1, 0, 1, 0},
    '{"1970-01-01T00:00:00Zjunk!",      0, 1, 0, 0, 1},
    '{"1970-01-01T00:00:00+01:00xyz",   0, 1, -64'sd3600, 0, 1},
    '{"Z",                              0, 1, 0, 1, 0},
    '{"1970-01-40T99:-5:70",         3600, 0, 0, 0, 0},
    '{"1970-01-01T00:00:00",       -50400, 1, 64'sd50400, 0, 0}
  };

  function automatic void append_byte(input logic [7:0] c);
    txt = {txt, c};
  endfunction

  function automatic void clear_number();
    scan_acc       = '0;
    scan_neg       = 1'b0;
    scan_digits    = 0;
    scan_sign_seen = 1'b0;
  endfunction

  function automatic void clear_scan();
    clear_number();
    scan_field = '0;
    scan_zone  = isoep_pkg::ZONE_NONE;
    scan_bad   = 1'b0;
    foreach (field_vals[i]) field_vals[i] = 0;
  endfunction

  function automatic void store_value();
    field_vals[scan_field[2:0]] = scan_neg ? -int'(scan_acc) : int'(scan_acc);
    clear_number();
  endfunction

  function automatic void scan_byte(input logic [7:0] c);
    logic [isoep_pkg::FI_W-1:0] f;
    if (scan_bad || scan_field >= isoep_pkg::FI_DONE) return;
    if (c >= isoep_pkg::CH_0 && c <= isoep_pkg::CH_9) begin
      if (scan_digits >= isoep_pkg::MAX_DIGITS) begin
        scan_bad = 1'b1;
        return;
      end
      scan_acc = scan_acc * 10 + 32'(c - isoep_pkg::CH_0);
      scan_digits++;
      return;
    end
    if (scan_digits == 0) begin
      if (!scan_sign_seen && (c == isoep_pkg::CH_SPACE ||
                              (c >= isoep_pkg::CH_TAB && c <= isoep_pkg::CH_CR))) return;
      if (!scan_sign_seen && (c == isoep_pkg::CH_PLUS || c == isoep_pkg::CH_MINUS)) begin
        scan_sign_seen = 1'b1;
        scan_neg = (c == isoep_pkg::CH_MINUS);
        return;
      end
      scan_bad = 1'b1;
      return;
    end
    // byte closes the number and must be the next separator, except after the zone minutes
    f = scan_field;
    store_value();
    case (f)
      4'd0, 4'd1: begin
        if (c == isoep_pkg::CH_MINUS) scan_field = f + 4'd1;
        else scan_bad = 1'b1;
      end
      4'd2: begin
        if (c == isoep_pkg::CH_T) scan_field = f + 4'd1;
        else scan_bad = 1'b1;
      end
      4'd3, 4'd4: begin
        if (c == isoep_pkg::CH_COLON) scan_field = f + 4'd1;
        else scan_bad = 1'b1;
      end
      isoep_pkg::FI_SEC: begin
        if (c == isoep_pkg::CH_Z) begin
          scan_zone  = isoep_pkg::ZONE_Z;
          scan_field = isoep_pkg::FI_DONE;
        end else if (c == isoep_pkg::CH_PLUS || c == isoep_pkg::CH_MINUS) begin
          scan_zone  = (c == isoep_pkg::CH_PLUS) ? isoep_pkg::ZONE_PLUS
                                                 : isoep_pkg::ZONE_MINUS;
          scan_field = isoep_pkg::FI_ZHOUR;
        end else begin
          scan_bad = 1'b1;
        end
      end
      isoep_pkg::FI_ZHOUR: begin
        if (c == isoep_pkg::CH_COLON) scan_field = isoep_pkg::FI_ZMIN;
        else scan_bad = 1'b1;
      end
      default: scan_field = isoep_pkg::FI_DONE;
    endcase
  endfunction

  function automatic longint civil_day_number(input longint y, input longint m,
                                              input longint d);
    longint era, yoe, mp, doy, doe;
    if (m <= 2) y = y - 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic epoch_result_t close_text();
    epoch_result_t              r;
    logic [isoep_pkg::FI_W-1:0] f;
    bit                         ok;
    longint                     secs, off;
    ok = !scan_bad;
    if (ok && scan_field < isoep_pkg::FI_DONE && scan_digits > 0) begin
      f = scan_field;
      store_value();
      if (f == isoep_pkg::FI_SEC || f == isoep_pkg::FI_ZMIN) scan_field = isoep_pkg::FI_DONE;
    end
    if (scan_field != isoep_pkg::FI_DONE || field_vals[isoep_pkg::FI_MONTH] < 1 ||
        field_vals[isoep_pkg::FI_MONTH] > 12)
      ok = 1'b0;
    secs = civil_day_number(field_vals[0], field_vals[1], field_vals[2]) * 86400
         + longint'(field_vals[3]) * 3600 + longint'(field_vals[4]) * 60
         + longint'(field_vals[5]);
    case (scan_zone)
      isoep_pkg::ZONE_PLUS:  off = longint'(field_vals[isoep_pkg::FI_ZHOUR]) * 3600
                                 + longint'(field_vals[isoep_pkg::FI_ZMIN]) * 60;
      isoep_pkg::ZONE_MINUS: off = -(longint'(field_vals[isoep_pkg::FI_ZHOUR]) * 3600
                                 + longint'(field_vals[isoep_pkg::FI_ZMIN]) * 60);
      isoep_pkg::ZONE_Z:     off = 0;
      default:               off = local_off;
    endcase
    r.epoch  = ok ? secs - off : '0;
    r.status = !ok;
    r.zone   = ok && scan_zone != isoep_pkg::ZONE_NONE;
    clear_scan();
    return r;
  endfunction

  // ---- text generation ----
  function automatic longint unsigned pick(input int unsigned lo, input int unsigned hi);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 90) return $urandom_range(hi, lo);
    if (roll < 95) return $urandom_range(99);
    return $urandom_range(999999999);
  endfunction

  function automatic void put_num(input longint unsigned v, input int width);
    logic [7:0] digs [$];
    if ($urandom_range(99) < 5)
      append_byte(($urandom_range(4) == 0) ? isoep_pkg::CH_SPACE
                                           : 8'(isoep_pkg::CH_TAB + $urandom_range(4)));
    if ($urandom_range(99) < 6)
      append_byte($urandom_range(1) ? isoep_pkg::CH_PLUS : isoep_pkg::CH_MINUS);
    do begin
      digs.push_front(8'(isoep_pkg::CH_0 + v % 10));
      v = v / 10;
    end while (v != 0);
    while (digs.size() < width) digs.push_front(isoep_pkg::CH_0);
    foreach (digs[i]) append_byte(digs[i]);
  endfunction

  function automatic void make_good();
    int zsel;
    txt.delete();
    put_num(pick(1900, 2100), 4);
    append_byte(isoep_pkg::CH_MINUS);
    put_num(pick(1, 12), 2);
    append_byte(isoep_pkg::CH_MINUS);
    put_num(pick(1, 31), 2);
    append_byte(isoep_pkg::CH_T);
    put_num(pick(0, 23), 2);
    append_byte(isoep_pkg::CH_COLON);
    put_num(pick(0, 59), 2);
    append_byte(isoep_pkg::CH_COLON);
    put_num(pick(0, 60), 2);
    zsel = $urandom_range(3);
    if (zsel == 1) append_byte(isoep_pkg::CH_Z);
    if (zsel >= 2) begin
      append_byte((zsel == 2) ? isoep_pkg::CH_PLUS : isoep_pkg::CH_MINUS);
      put_num(pick(0, 14), 2);
      append_byte(isoep_pkg::CH_COLON);
      put_num(pick(0, 59), 2);
    end
    if (zsel != 0 && $urandom_range(99) < 15)
      repeat ($urandom_range(4, 1)) append_byte(8'($urandom_range(255)));
  endfunction

  function automatic void make_broken();
    int cut, pos;
    make_good();
    case ($urandom_range(2))
      0: begin
        cut = $urandom_range(txt.size() - 1, 1);
        while (txt.size() > cut) void'(txt.pop_back());
      end
      1: txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
      default: begin
        pos = $urandom_range(txt.size() - 1);
        repeat (10) txt.insert(pos, 8'(isoep_pkg::CH_0 + $urandom_range(9)));
      end
    endcase
  endfunction

  function automatic void make_noise();
    txt.delete();
    repeat ($urandom_range(24, 1)) append_byte(8'($urandom_range(255)));
  endfunction

  // ---- driving ----
  task automatic send_byte(input logic [7:0] c, input logic last);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 8) gap = $urandom_range(4, 1);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= c;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    n_bytes++;
    scan_byte(c);
    if (last) begin
      n_texts++;
      pending_epochs = {pending_epochs, close_text()};
    end
  endtask

  task automatic send_text();
    foreach (txt[k]) send_byte(txt[k], k == txt.size() - 1);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_epochs.size() != 0) @(posedge clk);
    // idle on after the last result before the next step
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_local_offset(input int v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= isoep_pkg::OFFSET_W'(v);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    local_off = v;
    n_offsets++;
  endtask

  initial begin : stimulus
    int roll, phase_bytes, phase_texts, off;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_text_byte <= '0;
    in_last_byte <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    local_off = 0;
    clear_scan();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_cases[i].offset != local_off) set_local_offset(directed_cases[i].offset);
      txt.delete();
      for (int j = 0; j < directed_cases[i].text.len(); j++)
        append_byte(directed_cases[i].text[j]);
      send_text();
      if (directed_cases[i].typed)
        pending_epochs[$] = '{directed_cases[i].epoch, directed_cases[i].status,
                              directed_cases[i].zone};
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       off = -50400;
        1:       off = 50400;
        2:       off = 0;
        3:       off = int'($urandom_range(100800)) - 50400;
        default: off = -1;
      endcase
      set_local_offset(off);
      calm = (p == 2);
      phase_bytes = 0;
      phase_texts = 0;
      while (phase_bytes < PHASE_BYTES) begin
        roll = $urandom_range(99);
        if (roll < 70) make_good();
        else if (roll < 85) make_broken();
        else make_noise();
        // long output stall while texts keep coming
        if (p == 1 && phase_texts == 2) hold_req++;
        send_text();
        phase_bytes += txt.size();
        phase_texts++;
      end
    end

    drain_results();
    $display("Sent %0d texts in %0d bytes over %0d offset writes;",
             n_texts, n_bytes, n_offsets);
    $display("%0d results checked, %0d of them rejected texts", n_results, n_rejected);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---- result side ----
  initial begin : result_side
    epoch_result_t want;
    int hold_left, holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        n_results++;
        if (pending_epochs.size() == 0) begin
          $error("result transaction with no conversion pending");
          mismatches++;
        end else begin
          want = pending_epochs.pop_front();
          if (want.status) n_rejected++;
          if (out_epoch_seconds !== want.epoch) begin
            $error("epoch_seconds: expected %0d, got %0d", want.epoch, out_epoch_seconds);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_zone_given !== want.zone) begin
            $error("zone_given: expected %0d, got %0d", want.zone, out_zone_given);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_served != hold_req) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 17);
      end
    end
  end

  // ---- watchdog ----
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: filelist.f
src/isoep_pkg.sv
src/isoep_parser.sv
src/isoep_mac.sv
src/iso8601_to_epoch_parser_core.sv
sim/iso8601_to_epoch_parser_core_tb.sv
